FILE: hw/rtl/lfu_cache_lru_tiebreak_top_macros.svh
// Assertion macros shared by the cache RTL.
// Each macro expands to one labeled concurrent assertion on the rising clock edge.
`ifndef LFU_CACHE_LRU_TIEBREAK_TOP_MACROS_SVH
`define LFU_CACHE_LRU_TIEBREAK_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LFU_ASSERT_NOW(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LFU_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

FILE: hw/rtl/lfu_pkg.sv
// Shared types and constants for the frequency-ordered cache.
// Has no dependencies; every RTL module imports it.
`timescale 1ns / 1ps
package lfu_pkg;

   localparam int DEFAULT_MAX_ENTRIES = 16;
   localparam logic [4:0] CAPACITY_RESET = 5'd16;
   localparam logic CMD_GET = 1'b0;
   localparam logic CMD_PUT = 1'b1;
   localparam logic [31:0] READ_MISS = 32'hFFFF_FFFF;

   typedef struct packed {
      logic               cmd;
      logic signed [31:0] key;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic signed [31:0] read_value;
      logic               evicted;
      logic signed [31:0] evicted_key;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic update;
   } ctrl_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic rsp_free;
   } ctrl_status_type;

endpackage

FILE: hw/rtl/lfu_cache_lru_tiebreak_top.sv
// Top level of the frequency-ordered key-value cache.
// Instantiates lfu_ctrl and lfu_dp; types come from lfu_pkg.
//
// Usage: each request on req_ (valid/stall) is a get (cmd 0) or a put (cmd 1)
// with a key and a value. Every request yields exactly one response on rsp_,
// carrying hit, read_value, evicted and evicted_key. The csr_ port writes the
// capacity register; it is always ready and should be written only when the
// cache holds no request in flight.
// Throughput: one request is in process at a time. It is accepted in the
// idle state; the entry scan then reads the key, value and count memories
// one entry per cycle through a registered read, and the update state
// writes the memories and loads the result register. The next request may
// be accepted once the cache is back in the idle state.
// Stalls: the result register holds its response while rsp_stall is high;
// the next request may be accepted and scanned meanwhile, and its update
// waits until the result register is free.
// Reset (synchronous, active high) empties the cache, clears the output and
// sets the capacity to 16; no clearing pass is needed.
`timescale 1ns / 1ps
module lfu_cache_lru_tiebreak_top #(
   parameter int MAX_ENTRIES = lfu_pkg::DEFAULT_MAX_ENTRIES
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  lfu_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output lfu_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [4:0]       csr_data
);
   import lfu_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   // The capacity register takes a write in any cycle.
   assign csr_ready = 1'b1;

   lfu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   lfu_dp #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .csr_valid (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

endmodule

FILE: hw/rtl/lfu_ctrl.sv
// Sequencer for the cache: accept a request, scan all entries, then update.
// Depends on lfu_pkg for the command and status structs.
`timescale 1ns / 1ps
module lfu_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  lfu_pkg::ctrl_status_type status,
   output lfu_pkg::ctrl_cmd_type    cmd
);
   import lfu_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_UPDATE = 3'b100
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in   = state_ff;
      cmd.load   = 1'b0;
      cmd.scan   = 1'b0;
      cmd.update = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_done) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            // State changes and the result leave together once the output is free.
            if (status.rsp_free) begin
               cmd.update = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: hw/rtl/lfu_dp.sv
// Datapath of the cache: entry storage, scan trackers, rank cells and output register.
// Depends on lfu_pkg; assertions come from the shared macro header.
`timescale 1ns / 1ps
`include "lfu_cache_lru_tiebreak_top_macros.svh"
module lfu_dp #(
   parameter int MAX_ENTRIES = lfu_pkg::DEFAULT_MAX_ENTRIES
) (
   input  logic                     clock,
   input  logic                     reset,
   input  lfu_pkg::ctrl_cmd_type    cmd,
   output lfu_pkg::ctrl_status_type status,
   input  lfu_pkg::req_type         req_data,
   input  logic                     csr_valid,
   input  logic [4:0]               csr_data,
   output logic                     rsp_valid,
   output lfu_pkg::rsp_type         rsp_data,
   input  logic                     rsp_stall
);
   import lfu_pkg::*;

   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int CAP_W = (CNT_W > 5) ? CNT_W : 5;

   // Entry storage: keys, values and counts are memories read one entry a cycle.
   logic [31:0] key_mem   [MAX_ENTRIES];
   logic [31:0] value_mem [MAX_ENTRIES];
   logic [31:0] count_mem [MAX_ENTRIES];

   // Valid bits and recency ranks are per-entry cells updated in parallel.
   logic             valid_ff [MAX_ENTRIES];
   logic             valid_in [MAX_ENTRIES];
   logic [IDX_W-1:0] rank_ff  [MAX_ENTRIES];
   logic [IDX_W-1:0] rank_in  [MAX_ENTRIES];

   logic [4:0]       capacity_ff;
   logic [CNT_W-1:0] occupied_ff;
   req_type          req_ff;

   logic [CNT_W-1:0] scan_cnt_ff;
   logic             st_vld_ff;
   logic [IDX_W-1:0] st_idx_ff;
   logic [31:0]      rd_key_ff, rd_value_ff, rd_count_ff;

   logic             hit_ff;
   logic [IDX_W-1:0] slot_ff;
   logic [31:0]      m_value_ff, m_count_ff;
   logic [IDX_W-1:0] m_rank_ff;
   logic             vfound_ff;
   logic [IDX_W-1:0] vidx_ff;
   logic [31:0]      vcount_ff, vkey_ff;
   logic [IDX_W-1:0] vrank_ff;
   logic             free_found_ff;
   logic [IDX_W-1:0] free_idx_ff;

   logic             rsp_valid_ff;
   rsp_type          rsp_ff;

   logic             st_entry_vld;
   logic [IDX_W-1:0] st_rank;
   logic             cap_zero, do_touch, put_hit, miss_put, do_evict, do_insert;
   logic [IDX_W-1:0] ins_idx;
   logic [CAP_W-1:0] cap_eff;
   logic [31:0]      count_sat;
   rsp_type          result;

   assign status.scan_done = (scan_cnt_ff == CNT_W'(MAX_ENTRIES));
   assign status.rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data         = rsp_ff;

   assign st_entry_vld = valid_ff[st_idx_ff];
   assign st_rank      = rank_ff[st_idx_ff];

   // Decisions taken in the update cycle from the scan results.
   always_comb begin
      cap_eff   = (CAP_W'(capacity_ff) > CAP_W'(MAX_ENTRIES)) ?
                  CAP_W'(MAX_ENTRIES) : CAP_W'(capacity_ff);
      cap_zero  = (capacity_ff == 5'd0);
      do_touch  = hit_ff && (req_ff.cmd == CMD_GET || !cap_zero);
      put_hit   = hit_ff && req_ff.cmd == CMD_PUT && !cap_zero;
      miss_put  = !hit_ff && req_ff.cmd == CMD_PUT && !cap_zero;
      do_evict  = miss_put && vfound_ff && (CAP_W'(occupied_ff) >= cap_eff);
      do_insert = miss_put && (free_found_ff || do_evict);
      ins_idx   = (do_evict && (!free_found_ff || vidx_ff < free_idx_ff)) ?
                  vidx_ff : free_idx_ff;
      count_sat = (m_count_ff == 32'hFFFF_FFFF) ? m_count_ff : m_count_ff + 32'd1;

      result.hit         = hit_ff;
      result.read_value  = (req_ff.cmd == CMD_GET) ?
                           (hit_ff ? m_value_ff : READ_MISS) : 32'd0;
      result.evicted     = do_evict;
      result.evicted_key = do_evict ? vkey_ff : 32'd0;
   end

   // Rank and valid cells: touch, evict and insert applied in one step.
   always_comb begin
      for (int j = 0; j < MAX_ENTRIES; j++) begin
         valid_in[j] = valid_ff[j];
         rank_in[j]  = rank_ff[j];
         if (do_touch) begin
            if (IDX_W'(j) == slot_ff) begin
               rank_in[j] = '0;
            end else if (valid_ff[j] && rank_ff[j] < m_rank_ff) begin
               rank_in[j] = rank_ff[j] + IDX_W'(1);
            end
         end
         if (do_evict) begin
            if (IDX_W'(j) == vidx_ff) begin
               valid_in[j] = 1'b0;
            end else if (valid_ff[j] && rank_ff[j] > vrank_ff) begin
               rank_in[j] = rank_ff[j] - IDX_W'(1);
            end
         end
         if (do_insert) begin
            if (IDX_W'(j) == ins_idx) begin
               valid_in[j] = 1'b1;
               rank_in[j]  = '0;
            end else if (valid_in[j]) begin
               rank_in[j] = rank_in[j] + IDX_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CAPACITY_RESET;
         occupied_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         for (int j = 0; j < MAX_ENTRIES; j++) begin
            valid_ff[j] <= 1'b0;
         end
      end else begin
         if (csr_valid) begin
            capacity_ff <= csr_data;
         end
         if (cmd.update) begin
            rsp_valid_ff <= 1'b1;
            valid_ff     <= valid_in;
            if (do_insert && !do_evict) begin
               occupied_ff <= occupied_ff + CNT_W'(1);
            end
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Request capture, scan pipeline, trackers, and the result and rank loads of an update.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff        <= req_data;
         scan_cnt_ff   <= '0;
         st_vld_ff     <= 1'b0;
         hit_ff        <= 1'b0;
         vfound_ff     <= 1'b0;
         free_found_ff <= 1'b0;
      end
      if (cmd.scan) begin
         if (!status.scan_done) begin
            st_idx_ff   <= scan_cnt_ff[IDX_W-1:0];
            st_vld_ff   <= 1'b1;
            scan_cnt_ff <= scan_cnt_ff + CNT_W'(1);
         end else begin
            st_vld_ff <= 1'b0;
         end
         if (st_vld_ff) begin
            if (st_entry_vld) begin
               if (!hit_ff && rd_key_ff == req_ff.key) begin
                  hit_ff     <= 1'b1;
                  slot_ff    <= st_idx_ff;
                  m_value_ff <= rd_value_ff;
                  m_count_ff <= rd_count_ff;
                  m_rank_ff  <= st_rank;
               end
               if (!vfound_ff || rd_count_ff < vcount_ff ||
                   (rd_count_ff == vcount_ff && st_rank > vrank_ff)) begin
                  vfound_ff <= 1'b1;
                  vidx_ff   <= st_idx_ff;
                  vcount_ff <= rd_count_ff;
                  vrank_ff  <= st_rank;
                  vkey_ff   <= rd_key_ff;
               end
            end else if (!free_found_ff) begin
               free_found_ff <= 1'b1;
               free_idx_ff   <= st_idx_ff;
            end
         end
      end
      if (cmd.update) begin
         rsp_ff  <= result;
         rank_ff <= rank_in;
      end
   end

   // Memories: one registered read at the scan address, one write per update.
   always_ff @(posedge clock) begin
      rd_key_ff   <= key_mem[scan_cnt_ff[IDX_W-1:0]];
      rd_value_ff <= value_mem[scan_cnt_ff[IDX_W-1:0]];
      rd_count_ff <= count_mem[scan_cnt_ff[IDX_W-1:0]];
      if (cmd.update) begin
         if (do_insert) begin
            key_mem[ins_idx]   <= req_ff.key;
            value_mem[ins_idx] <= req_ff.value;
            count_mem[ins_idx] <= 32'd1;
         end else if (do_touch) begin
            count_mem[slot_ff] <= count_sat;
            if (put_hit) begin
               value_mem[slot_ff] <= req_ff.value;
            end
         end
      end
   end

   `LFU_ASSERT_NOW(a_occ_bound, 1'b1, occupied_ff <= CNT_W'(MAX_ENTRIES), "occupancy overflow")
   `LFU_ASSERT_NOW(a_evict_inserts, cmd.update && do_evict, do_insert, "evict without insert")
   `LFU_ASSERT_NOW(a_update_free, cmd.update, status.rsp_free, "result overwrote pending")
   `LFU_ASSERT_NOW(a_hit_valid, cmd.update && hit_ff, valid_ff[slot_ff], "hit on invalid slot")

endmodule

FILE: tb/lfu_cache_lru_tiebreak_top_tb.sv
// Self-checking testbench for the frequency-ordered key-value cache.
// Depends on lfu_pkg and lfu_cache_lru_tiebreak_top; a scoreboard class predicts every response.
`timescale 1ns / 1ps

class lfu_scoreboard;
   localparam int NENT = 16;
   logic [4:0]  capacity;
   bit          ent_valid [NENT];
   logic [31:0] ent_key   [NENT];
   logic [31:0] ent_value [NENT];
   logic [31:0] ent_count [NENT];
   int unsigned ent_rank  [NENT];
   int unsigned fill;
   lfu_pkg::rsp_type pending [$];
   int unsigned mismatches;
   int unsigned checked;
   int unsigned hits;
   int unsigned evictions;

   function new();
      capacity = lfu_pkg::CAPACITY_RESET;
      for (int i = 0; i < NENT; i++) begin
         ent_valid[i] = 0;
         ent_key[i] = '0;
         ent_value[i] = '0;
         ent_count[i] = '0;
         ent_rank[i] = 0;
      end
      fill = 0;
      mismatches = 0;
      checked = 0;
      hits = 0;
      evictions = 0;
   endfunction

   // Promote one entry to most recent and bump its saturating use count.
   function void promote(int slot);
      int unsigned r;
      r = ent_rank[slot];
      for (int i = 0; i < NENT; i++)
         if (ent_valid[i] && i != slot && ent_rank[i] < r) ent_rank[i]++;
      ent_rank[slot] = 0;
      if (ent_count[slot] != 32'hFFFF_FFFF) ent_count[slot]++;
   endfunction

   // Note an accepted request and queue the response it must produce.
   function void note_request(lfu_pkg::req_type rq);
      lfu_pkg::rsp_type rs;
      int slot, victim, freeslot;
      bit found;
      int unsigned cap;
      cap = (capacity > NENT) ? NENT : capacity;
      rs = '0;
      slot = -1;
      for (int i = 0; i < NENT; i++)
         if (slot < 0 && ent_valid[i] && ent_key[i] == rq.key) slot = i;
      rs.hit = (slot >= 0);
      if (rq.cmd == lfu_pkg::CMD_GET) begin
         if (slot >= 0) begin
            rs.read_value = ent_value[slot];
            promote(slot);
         end else begin
            rs.read_value = lfu_pkg::READ_MISS;
         end
      end else if (cap != 0) begin
         if (slot >= 0) begin
            ent_value[slot] = rq.value;
            promote(slot);
         end else begin
            if (fill >= cap) begin
               found = 0;
               victim = 0;
               for (int i = 0; i < NENT; i++) begin
                  if (ent_valid[i] && (!found || ent_count[i] < ent_count[victim] ||
                      (ent_count[i] == ent_count[victim] &&
                       ent_rank[i] > ent_rank[victim]))) begin
                     victim = i;
                     found = 1;
                  end
               end
               if (found) begin
                  for (int i = 0; i < NENT; i++)
                     if (ent_valid[i] && i != victim && ent_rank[i] > ent_rank[victim])
                        ent_rank[i]--;
                  ent_valid[victim] = 0;
                  rs.evicted = 1;
                  rs.evicted_key = ent_key[victim];
                  if (fill > 0) fill--;
               end
            end
            freeslot = -1;
            for (int i = 0; i < NENT; i++)
               if (freeslot < 0 && !ent_valid[i]) freeslot = i;
            if (freeslot >= 0) begin
               for (int j = 0; j < NENT; j++)
                  if (ent_valid[j]) ent_rank[j]++;
               ent_valid[freeslot] = 1;
               ent_key[freeslot] = rq.key;
               ent_value[freeslot] = rq.value;
               ent_count[freeslot] = 1;
               ent_rank[freeslot] = 0;
               fill++;
            end
         end
      end
      if (rs.hit) hits++;
      if (rs.evicted) evictions++;
      pending.push_back(rs);
   endfunction

   // Compare one accepted response with the oldest queued one.
   function void check_response(lfu_pkg::rsp_type got);
      lfu_pkg::rsp_type exp_rs;
      checked++;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("ERROR: unexpected response %h", got);
         return;
      end
      exp_rs = pending.pop_front();
      if (got.hit !== exp_rs.hit || got.read_value !== exp_rs.read_value ||
          got.evicted !== exp_rs.evicted || got.evicted_key !== exp_rs.evicted_key) begin
         mismatches++;
         if (mismatches <= 10)
            $display("ERROR: response hit/value/evicted/key exp %0b %h %0b %h got %0b %h %0b %h",
                     exp_rs.hit, exp_rs.read_value, exp_rs.evicted, exp_rs.evicted_key,
                     got.hit, got.read_value, got.evicted, got.evicted_key);
      end
   endfunction
endclass

module lfu_cache_lru_tiebreak_top_tb;
   import lfu_pkg::*;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;
   logic    csr_valid;
   logic    csr_ready;
   logic [4:0] csr_data;

   lfu_scoreboard sb;
   // Keys are drawn mostly from a small pool so that hits, updates and
   // evictions are frequent; the pool is refreshed between phases.
   logic [31:0] key_pool [24];
   int unsigned sent;
   // Receiver hold-off control: when hold_req is set the receiver stalls for the
   // hold-off that hold_cycles sets, regardless of its random pattern.
   int unsigned hold_cycles;
   bit          hold_req;
   bit          stall_random;

   lfu_cache_lru_tiebreak_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Sample both channels at the rising edge. Accepted requests are fed to
   // the scoreboard here, so prediction order matches acceptance order.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_request(req_data);
         if (rsp_valid && !rsp_stall) sb.check_response(rsp_data);
      end
   end

   // Receiver: a stall pattern of its own. It alternates between phases with
   // no stalls, light stalls and heavy stalls, and honors a requested long
   // hold-off that is counted here, cycle by cycle.
   initial begin
      int unsigned mode, left, cnt;
      rsp_stall = 1'b1;
      mode = 0;
      left = 0;
      @(negedge clock);
      while (1) begin
         @(negedge clock);
         if (hold_req) begin
            rsp_stall <= 1'b1;
            for (cnt = 1; cnt < hold_cycles; cnt++) @(negedge clock);
            hold_req = 0;
         end else begin
            if (left == 0) begin
               mode = $urandom_range(0, 2);
               left = $urandom_range(10, 200);
            end
            left--;
            if (!stall_random || mode == 0) rsp_stall <= 1'b0;
            else if (mode == 1) rsp_stall <= ($urandom_range(0, 3) == 0);
            else rsp_stall <= ($urandom_range(0, 3) != 0);
         end
      end
   end

   // Offer one request and hold it until the cache accepts it.
   task automatic send_request(input logic cmd, input logic [31:0] key,
                               input logic [31:0] value);
      req_valid <= 1'b1;
      req_data <= '{cmd: cmd, key: key, value: value};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
      @(negedge clock);
   endtask

   task automatic idle_gap(input int unsigned cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // Write the capacity only when nothing is in flight. Every request gives
   // one response, so an empty expectation queue means the cache is idle.
   task automatic write_capacity(input logic [4:0] cap);
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= cap;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.capacity = cap;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [31:0] pick_key();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r < 8) return key_pool[$urandom_range(0, 23)];
      return $urandom();
   endfunction

   // A phase of random traffic in bursts with random gaps. Most requests
   // use the pool so the cache fills, hits and evicts; puts and gets are
   // equally likely.
   task automatic random_phase(input int unsigned count);
      int unsigned burst, n;
      logic cmd;
      logic [31:0] v;
      for (int i = 0; i < 24; i++) key_pool[i] = $urandom();
      n = 0;
      while (n < count) begin
         burst = $urandom_range(1, 20);
         for (int b = 0; b < burst && n < count; b++) begin
            cmd = ($urandom_range(0, 9) < 5) ? CMD_PUT : CMD_GET;
            v = $urandom();
            send_request(cmd, pick_key(), v);
            n++;
         end
         if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 30));
      end
   endtask

   initial begin
      logic [4:0] caps [6];
      sb = new();
      sent = 0;
      hold_cycles = 0;
      hold_req = 0;
      stall_random = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part at reset capacity: get miss on an empty cache, puts
      // of the extreme keys and values, get hits, a put that updates, and
      // a key of zero, which must not match the never-written entries.
      send_request(CMD_GET, 32'h0000_0000, 32'hFFFF_FFFF);
      send_request(CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
      send_request(CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
      send_request(CMD_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
      send_request(CMD_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
      send_request(CMD_GET, 32'h8000_0000, 32'h0);
      send_request(CMD_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_request(CMD_PUT, 32'h7FFF_FFFF, 32'h1234_5678);
      send_request(CMD_GET, 32'h7FFF_FFFF, 32'h0);
      send_request(CMD_GET, 32'h0000_0001, 32'h0);

      // Capacity two: the cache is over capacity, so each put miss evicts
      // one entry; among equal counts the oldest goes first.
      write_capacity(5'd2);
      send_request(CMD_PUT, 32'h0000_0010, 32'h1);
      send_request(CMD_PUT, 32'h0000_0011, 32'h2);
      send_request(CMD_GET, 32'h0000_0010, 32'h0);
      send_request(CMD_PUT, 32'h0000_0012, 32'h3);

      // Capacity zero: puts change nothing but still report presence.
      write_capacity(5'd0);
      send_request(CMD_PUT, 32'h0000_0010, 32'h5);
      send_request(CMD_PUT, 32'h0000_0099, 32'h6);
      send_request(CMD_GET, 32'h0000_0010, 32'h0);

      // Capacity above the entry count behaves as sixteen.
      write_capacity(5'd31);
      for (int i = 0; i < 6; i++) send_request(CMD_PUT, 32'h100 + i, i);

      // Random part, phase by phase across capacities including both ends.
      stall_random = 1;
      caps = '{5'd16, 5'd1, 5'd4, 5'd0, 5'd31, 5'd7};
      foreach (caps[p]) begin
         write_capacity(caps[p]);
         random_phase(160);
         if (p == 1) begin
            // Long hold-off on the receiver while requests keep coming, so
            // the result register fills and the input stalls.
            hold_cycles = 300;
            hold_req = 1;
            random_phase(20);
         end
      end

      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      $display("Covered %0d requests, %0d responses, %0d hits, %0d evictions.",
               sent, sb.checked, sb.hits, sb.evictions);
      $display("Capacities 0, 1, 2, 4, 7, 16 and 31 were exercised.");
      if (sb.mismatches == 0 && sb.pending.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("%0d mismatches", sb.mismatches);
         $display("Some tests failed");
      end
      $finish;
   end

   // The test sends about 1000 requests, each with its scan, plus stalls and
   // gaps; this limit is well above the time that all of that takes.
   initial begin
      #8_000_000;
      $display("Timeout");
      $display("Some tests failed");
      $finish;
   end
endmodule
